### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/rmsw_pkg.sv
package rmsw_pkg;

   // defaults for the top-level parameters
   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   // fixed field widths of the channel words
   localparam int SAMPLE_W    = 16;
   localparam int RMS_W       = 16;
   localparam int COUNT_OUT_W = 13;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

### hdl/rmsw_if.sv
// sample channel
interface rmsw_req_if;
   import rmsw_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink   (input valid, sample, last_sample, output ready);
endinterface

// result channel
interface rmsw_rsp_if;
   import rmsw_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [RMS_W-1:0]       rms_value;
   logic [COUNT_OUT_W-1:0] window_count;
   logic                   empty_window;
   logic                   overrun;

   modport source (output valid, rms_value, window_count, empty_window, overrun,
                   input ready);
   modport sink   (input valid, rms_value, window_count, empty_window, overrun,
                   output ready);
endinterface

### hdl/rmsw_csub.sv
// Shared compare-and-subtract unit: one step of restoring division or of
// the digit-by-digit square root.
module rmsw_csub #(
   parameter int WIDTH = 18
) (
   input  logic [WIDTH-1:0] minuend,
   input  logic [WIDTH-1:0] subtrahend,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);

   logic borrow;

   // one wide subtract; no borrow means minuend >= subtrahend
   assign {borrow, diff} = {1'b0, minuend} - {1'b0, subtrahend};
   assign ge = ~borrow;

endmodule

### hdl/true_rms_window_top.sv
// A sample without the last mark is taken at once and ready stays high.
// A last sample starts 2*SAMPLE_BITS-1+clog2(MAX_SAMPLES+1) division steps and
// SAMPLE_BITS root steps on one shared subtractor, then loads the result once the
// result register is free or being read; ready is low meanwhile, so throughput is one
// word per cycle within a window and none until the result is loaded. Reset (synchronous)
// clears the running sum, count, overrun flag, sequencer and result valid.
`include "assert_macros.svh"

module true_rms_window_top #(
   parameter int MAX_SAMPLES = rmsw_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = rmsw_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rmsw_req_if.sink    req,
   rmsw_rsp_if.source  rsp
);
   import rmsw_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = 2 * SAMPLE_BITS - 1 + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS;
   localparam int ROOT_W = SAMPLE_BITS;
   localparam int SUB_W  = (CNT_W + 1 > ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int EXT_W  = SAMPLE_BITS + SAMPLE_W;

   // control registers
   state_type          state_ff, state_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               drop_ff, drop_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [SUM_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0]   div_ff, div_in;
   logic [SUB_W-1:0]   rem_ff, rem_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic               empty_ff, empty_in;
   logic               ovr_ff, ovr_in;

   // result word registers
   logic [RMS_W-1:0]       rms_ff, rms_in;
   logic [COUNT_OUT_W-1:0] wcount_ff, wcount_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_ovr_ff, rsp_ovr_in;

   // sample magnitude and square
   logic [EXT_W-1:0]       sample_ext;
   logic [SAMPLE_BITS-1:0] samp_v;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SQ_W-1:0]        square;
   logic                   room;
   logic [SUM_W-1:0]       sum_acc;
   logic [CNT_W-1:0]       cnt_acc;
   logic                   drop_acc;
   logic                   take;

   // shared unit operands
   logic [CNT_W:0]     div_trial;
   logic [ROOT_W+1:0]  root_trial;
   logic [ROOT_W+1:0]  root_sub;
   logic [SUB_W-1:0]   unit_a, unit_b, unit_diff;
   logic               unit_ge;

   // sequencer outputs
   logic               div_last, root_last, load_rsp, sat;

   assign sample_ext = {{SAMPLE_BITS{1'b0}}, req.sample};
   assign samp_v     = sample_ext[SAMPLE_BITS-1:0];
   assign mag        = samp_v[SAMPLE_BITS-1]
                       ? (~samp_v) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1} : samp_v;
   assign square     = SQ_W'(mag) * SQ_W'(mag);

   // accumulate while the window has room
   assign room     = count_ff < CNT_W'(MAX_SAMPLES);
   assign sum_acc  = room ? sum_ff + SUM_W'(square) : sum_ff;
   assign cnt_acc  = room ? count_ff + {{(CNT_W-1){1'b0}}, 1'b1} : count_ff;
   assign drop_acc = drop_ff | ~room;
   assign take     = req.valid & req.ready;

   // one step operands for division and root
   assign div_trial  = {rem_ff[CNT_W-1:0], quot_ff[SUM_W-1]};
   assign root_trial = {rem_ff[ROOT_W-1:0], sq_ff[SQ_W-1:SQ_W-2]};
   assign root_sub   = {root_ff, 2'b01};

   always_comb begin
      unique case (state_ff)
         ST_DIV: begin
            unit_a = SUB_W'(div_trial);
            unit_b = SUB_W'(div_ff);
         end
         ST_ROOT: begin
            unit_a = SUB_W'(root_trial);
            unit_b = SUB_W'(root_sub);
         end
         default: begin
            unit_a = '0;
            unit_b = '0;
         end
      endcase
   end

   rmsw_csub #(
      .WIDTH (SUB_W)
   ) u_csub (
      .minuend    (unit_a),
      .subtrahend (unit_b),
      .diff       (unit_diff),
      .ge         (unit_ge)
   );

   assign div_last  = step_ff == STEP_W'(SUM_W - 1);
   assign root_last = step_ff == STEP_W'(ROOT_W - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req.last_sample) begin
               state_in = (cnt_acc == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_last) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req.ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req.ready = 1'b1;
         ST_DONE: load_rsp  = ~rsp_valid_ff | rsp.ready;
         default: begin
            req.ready = 1'b0;
            load_rsp  = 1'b0;
         end
      endcase
   end

   // window accumulators and step datapath
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      step_in  = step_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      sq_in    = sq_ff;
      root_in  = root_ff;
      empty_in = empty_ff;
      ovr_in   = ovr_ff;

      if (take) begin
         if (req.last_sample) begin
            sum_in   = '0;
            count_in = '0;
            drop_in  = 1'b0;
            quot_in  = sum_acc;
            div_in   = cnt_acc;
            empty_in = cnt_acc == '0;
            ovr_in   = drop_acc;
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
         end else begin
            sum_in   = sum_acc;
            count_in = cnt_acc;
            drop_in  = drop_acc;
         end
      end

      // restoring division, one quotient bit per cycle
      if (state_ff == ST_DIV) begin
         rem_in  = unit_ge ? unit_diff : SUB_W'(div_trial);
         quot_in = {quot_ff[SUM_W-2:0], unit_ge};
         step_in = step_ff + {{(STEP_W-1){1'b0}}, 1'b1};
         if (div_last) begin
            sq_in   = SQ_W'({quot_ff[SUM_W-2:0], unit_ge});
            rem_in  = '0;
            root_in = '0;
            step_in = '0;
         end
      end

      // digit-by-digit root, one root bit per cycle
      if (state_ff == ST_ROOT) begin
         rem_in  = unit_ge ? unit_diff : SUB_W'(root_trial);
         root_in = {root_ff[ROOT_W-2:0], unit_ge};
         sq_in   = {sq_ff[SQ_W-3:0], 2'b00};
         step_in = step_ff + {{(STEP_W-1){1'b0}}, 1'b1};
      end
   end

   // result word
   assign sat          = |(root_ff >> RMS_W);
   assign rms_in       = (empty_ff || load_rsp == 1'b0) ? ((empty_ff) ? '0 : rms_ff)
                         : (sat ? '1 : RMS_W'(root_ff));
   assign wcount_in    = load_rsp ? COUNT_OUT_W'(div_ff) : wcount_ff;
   assign rsp_empty_in = load_rsp ? empty_ff : rsp_empty_ff;
   assign rsp_ovr_in   = load_rsp ? ovr_ff : rsp_ovr_ff;
   assign rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      sq_ff    <= sq_in;
      root_ff  <= root_in;
      empty_ff <= empty_in;
      ovr_ff   <= ovr_in;
      if (load_rsp) begin
         rms_ff <= rms_in;
      end
      wcount_ff    <= wcount_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovr_ff   <= rsp_ovr_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.rms_value    = rms_ff;
   assign rsp.window_count = wcount_ff;
   assign rsp.empty_window = rsp_empty_ff;
   assign rsp.overrun      = rsp_ovr_ff;

   // checks
   `ASSERT_NEXT(a_busy_after_last, clock, reset, take && req.last_sample, !req.ready, "ready high after last word")
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_SAMPLES), "window count above maximum")
   `ASSERT_ALWAYS(a_empty_zero, clock, reset, !(rsp.valid && rsp.empty_window) || rsp.rms_value == '0, "empty window with nonzero rms")

endmodule

### tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rmsw_pkg::*;

   localparam int MAX_SAMPLES  = MAX_SAMPLES_DEF;
   // closing word: division plus root steps plus load
   localparam int CLOSE_CYCLES = 2 * SAMPLE_BITS_DEF - 1 + $clog2(MAX_SAMPLES + 1)
                                 + SAMPLE_BITS_DEF + 1;
   localparam int SETTLE_CYCLES = CLOSE_CYCLES + 20;
   localparam int RANDOM_WORDS  = 1150;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int IDLE_MAX      = 17;

   typedef struct packed {
      logic [RMS_W-1:0]       rms_value;
      logic [COUNT_OUT_W-1:0] window_count;
      logic                   empty_window;
      logic                   overrun;
   } rms_result_type;

   logic clock;
   logic reset;

   rmsw_req_if req ();
   rmsw_rsp_if rsp ();

   true_rms_window_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // running window state of the predictor
   logic [42:0]            sq_sum;
   logic [COUNT_OUT_W-1:0] taken_count;
   logic                   drop_seen;

   rms_result_type rms_expect[$];
   rms_result_type rms_got;
   rms_result_type rms_want;

   int  mismatches  = 0;
   int  cycle_count = 0;
   bit  send_steady = 0;   // sender never idles when set
   bit  recv_steady = 0;   // receiver never stalls when set

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL true_rms_window_top");
         $finish;
      end
   end

   // floor square root by setting bits from the top down
   function automatic logic [31:0] floor_sqrt(input logic [63:0] m);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= m)
            root = trial;
      end
      return root[31:0];
   endfunction

   // fold one accepted word into the window; returns a result on the last mark
   task automatic window_accumulate(input logic signed [SAMPLE_W-1:0] s, input logic lst);
      logic [SAMPLE_W:0] mag;
      logic [33:0]       square;
      logic [31:0]       root;
      rms_result_type    res;
      mag    = s[SAMPLE_W-1] ? (~{1'b1, s} + 1'b1) : {1'b0, s};
      square = mag * mag;
      if (taken_count < MAX_SAMPLES) begin
         sq_sum      = sq_sum + square;
         taken_count = taken_count + 1'b1;
      end else begin
         drop_seen = 1'b1;
      end
      if (lst) begin
         res.empty_window = (taken_count == 0);
         res.window_count = taken_count;
         res.overrun      = drop_seen;
         root = res.empty_window ? 32'd0 : floor_sqrt(64'(sq_sum / taken_count));
         res.rms_value = (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
         rms_expect.push_back(res);
         sq_sum      = '0;
         taken_count = '0;
         drop_seen   = 1'b0;
      end
   endtask

   function automatic int idle_draw(input bit steady);
      return steady ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   // send one word; entered and left at a falling edge, valid stays high on exit
   task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic lst);
      int gap;
      gap = idle_draw(send_steady);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.sample      <= s;
      req.last_sample <= lst;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      window_accumulate(s, lst);
      @(negedge clock);
   endtask

   // hold off until every result is back, then let the sequencer settle
   task automatic drain_results();
      req.valid <= 1'b0;
      @(negedge clock);
      while (rms_expect.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($urandom_range(0, 16) - 8);
         3:       return 16'($urandom_range(0, 2047) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   // one-word windows at the field extremes and alternating bit patterns
   task automatic test_single_word_windows();
      send_word(16'sh0000, 1'b1);
      send_word(16'sh0001, 1'b1);
      send_word(-16'sd1, 1'b1);
      send_word(16'sh7FFF, 1'b1);
      send_word(16'sh8000, 1'b1);
      send_word(16'sh5555, 1'b1);
      send_word(16'shAAAA, 1'b1);
   endtask

   // short mixed windows: sign symmetry and extremes together
   task automatic test_short_windows();
      send_word(16'sh7FFF, 1'b0);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh0000, 1'b1);
      send_word(16'sd100, 1'b0);
      send_word(-16'sd100, 1'b0);
      send_word(16'sd100, 1'b0);
      send_word(-16'sd100, 1'b1);
      send_word(16'sd3, 1'b0);
      send_word(16'sd4, 1'b1);
   endtask

   // full window of most-negative words (largest root), then two dropped words,
   // the last of them carrying the last mark
   task automatic test_full_window();
      for (int i = 0; i < MAX_SAMPLES + 2; i++)
         send_word(16'sh8000, i == MAX_SAMPLES + 1);
   endtask

   // random windows, mostly short, with idle modes switched per window
   task automatic test_random_windows();
      int words;
      int wlen;
      int windows;
      words   = 0;
      windows = 0;
      while (words < RANDOM_WORDS) begin
         case ($urandom_range(0, 19))
            0:       wlen = $urandom_range(100, 400);
            1, 2, 3: wlen = $urandom_range(17, 100);
            default: wlen = $urandom_range(1, 16);
         endcase
         send_steady = ($urandom_range(0, 3) == 0);
         recv_steady = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < wlen; i++)
            send_word(pick_sample(), i == wlen - 1);
         words   += wlen;
         windows += 1;
         if (windows % 15 == 0)
            drain_results();
      end
      send_steady = 0;
      recv_steady = 0;
   endtask

   // result receiver with random stalls
   initial begin
      int gap;
      rsp.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = idle_draw(recv_steady);
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (rsp.valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic field_check(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         rms_got.rms_value    = rsp.rms_value;
         rms_got.window_count = rsp.window_count;
         rms_got.empty_window = rsp.empty_window;
         rms_got.overrun      = rsp.overrun;
         if (rms_expect.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, rms_got);
            mismatches++;
         end else begin
            rms_want = rms_expect.pop_front();
            field_check("rms_value", rms_want.rms_value, rms_got.rms_value);
            field_check("window_count", rms_want.window_count, rms_got.window_count);
            field_check("empty_window", rms_want.empty_window, rms_got.empty_window);
            field_check("overrun", rms_want.overrun, rms_got.overrun);
         end
      end
   end

   // main sequence
   initial begin
      sq_sum          = '0;
      taken_count     = '0;
      drop_seen       = 1'b0;
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.sample      = '0;
      req.last_sample = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_word_windows();
      test_short_windows();
      drain_results();
      test_full_window();
      test_random_windows();

      req.valid <= 1'b0;
      while (rms_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS true_rms_window_top");
      else
         $display("FAIL true_rms_window_top");
      $finish;
   end

endmodule
